[src/smtl_pkg.sv]
// Shared types, constants and the signed word compare for sort_and_merge_two_lists.
// No dependencies; the sorter, the top block and the testbench import this package.
package smtl_pkg;

    localparam int MAX_PER_LIST = 32;
    localparam int WORD_W       = 32;
    localparam int ADDR_W       = (MAX_PER_LIST > 1) ? $clog2(MAX_PER_LIST) : 1;
    localparam int CNT_W        = $clog2(MAX_PER_LIST + 1);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // One cycle's worth of access to a list memory.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } ram_req_t;

    function automatic logic word_le(input word_t x, input word_t y);
        return x <= y;
    endfunction

endpackage

[src/smtl_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module smtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/smtl_sorter.sv]
// In-place bubble sort sequencer driving one list memory through its single ports.
// Depends on smtl_pkg.
module smtl_sorter
    import smtl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  cnt_t     count,
    input  word_t    rdata,
    output ram_req_t req,
    output logic     busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_TAIL  = 2'd3;

    logic [1:0] state_reg, state_next;
    addr_t      lim_reg, lim_next;
    addr_t      idx_reg, idx_next;
    word_t      cur_reg, cur_next;

    // Each pass carries the largest word seen so far up to position lim, writing
    // the smaller of each pair one place behind the word just read.
    always_comb begin
        state_next = state_reg;
        lim_next   = lim_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        req        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start && (count > CNT_W'(1))) begin
                    lim_next   = ADDR_W'(count - CNT_W'(1));
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                cur_next   = rdata;
                req.raddr  = ADDR_W'(1);
                idx_next   = ADDR_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                req.we    = 1'b1;
                req.waddr = idx_reg - ADDR_W'(1);
                if (word_le(cur_reg, rdata)) begin
                    req.wdata = cur_reg;
                    cur_next  = rdata;
                end else begin
                    req.wdata = rdata;
                end
                if (idx_reg == lim_reg) begin
                    state_next = ST_TAIL;
                end else begin
                    req.raddr = idx_reg + ADDR_W'(1);
                    idx_next  = idx_reg + ADDR_W'(1);
                end
            end
            ST_TAIL: begin
                req.we    = 1'b1;
                req.waddr = lim_reg;
                req.wdata = cur_reg;
                if (lim_reg == ADDR_W'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    lim_next   = lim_reg - ADDR_W'(1);
                    state_next = ST_FIRST;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        lim_reg <= lim_next;
        idx_reg <= idx_next;
        cur_reg <= cur_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[src/sort_and_merge_two_lists.sv]
// Loading: one word per cycle; no word is taken while the block sorts and merges.
// After the end-of-load word comes a start state, then each list of n words is bubble
// sorted in its own memory (no sorting for n < 2), the longer list setting the time, then
// the block hands over to the merge. Merged words then follow one per cycle while they
// are taken.
// Reset (aresetn low, synchronous) clears the control states, counts, overflow flag and output valid only.
module sort_and_merge_two_lists
    import smtl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  word_t s_tdata,   // element_value
    input  logic  s_tlast,   // end_of_load
    input  logic  s_tuser,   // command: 0 first list, 1 second list
    output logic  m_tvalid,
    input  logic  m_tready,
    output word_t m_tdata,   // merged_value
    output logic  m_tlast,   // last_of_run
    output logic  m_tuser    // dropped_flag
);

    localparam logic [1:0] T_LOAD  = 2'd0;
    localparam logic [1:0] T_START = 2'd1;
    localparam logic [1:0] T_SORT  = 2'd2;
    localparam logic [1:0] T_MERGE = 2'd3;

    logic [1:0] state_reg, state_next;
    cnt_t       ca_reg, ca_next, cb_reg, cb_next;
    cnt_t       ia_reg, ia_next, ib_reg, ib_next;
    logic       ovf_reg, ovf_next;
    logic       mvalid_reg, mvalid_next;
    word_t      mdata_reg, mdata_next;
    logic       mlast_reg, mlast_next;
    logic       muser_reg, muser_next;

    ram_req_t   req_a, req_b, sreq_a, sreq_b;
    word_t      rdata_a, rdata_b;
    logic       busy_a, busy_b;
    logic       accept, emit, take_a, is_last, sort_start;
    logic [CNT_W:0] total, done_cnt;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == T_LOAD);
    assign sort_start = (state_reg == T_START);
    assign total      = {1'b0, ca_reg} + {1'b0, cb_reg};
    assign done_cnt   = {1'b0, ia_reg} + {1'b0, ib_reg};
    assign is_last    = (done_cnt + (CNT_W + 1)'(1)) == total;
    assign emit       = (state_reg == T_MERGE) && (!mvalid_reg || m_tready);
    assign take_a     = (ia_reg < ca_reg) &&
                        ((ib_reg >= cb_reg) || word_le(rdata_a, rdata_b));

    smtl_sorter u_sort_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sort_start),
        .count   (ca_reg),
        .rdata   (rdata_a),
        .req     (sreq_a),
        .busy    (busy_a)
    );

    smtl_sorter u_sort_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sort_start),
        .count   (cb_reg),
        .rdata   (rdata_b),
        .req     (sreq_b),
        .busy    (busy_b)
    );

    always_comb begin
        state_next  = state_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        ovf_next    = ovf_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        req_a       = '0;
        req_b       = '0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            T_LOAD: begin
                req_a.waddr = ADDR_W'(ca_reg);
                req_a.wdata = s_tdata;
                req_b.waddr = ADDR_W'(cb_reg);
                req_b.wdata = s_tdata;
                if (accept) begin
                    if (!s_tuser) begin
                        if (ca_reg < CNT_W'(MAX_PER_LIST)) begin
                            req_a.we = 1'b1;
                            ca_next  = ca_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        if (cb_reg < CNT_W'(MAX_PER_LIST)) begin
                            req_b.we = 1'b1;
                            cb_next  = cb_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = T_START;
                    end
                end
            end
            T_START: begin
                req_a      = sreq_a;
                req_b      = sreq_b;
                state_next = T_SORT;
            end
            T_SORT: begin
                // Idle sorters point their read ports at entry 0, which primes the merge.
                req_a = sreq_a;
                req_b = sreq_b;
                if (!busy_a && !busy_b) begin
                    ia_next    = '0;
                    ib_next    = '0;
                    state_next = T_MERGE;
                end
            end
            T_MERGE: begin
                if (emit) begin
                    mvalid_next = 1'b1;
                    mlast_next  = is_last;
                    muser_next  = ovf_reg;
                    if (take_a) begin
                        mdata_next = rdata_a;
                        ia_next    = ia_reg + CNT_W'(1);
                    end else begin
                        mdata_next = rdata_b;
                        ib_next    = ib_reg + CNT_W'(1);
                    end
                    if (is_last) begin
                        ca_next    = '0;
                        cb_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = T_LOAD;
                    end
                end
                // Reading at the next index keeps each list head on the read data.
                req_a.raddr = ADDR_W'(ia_next);
                req_b.raddr = ADDR_W'(ib_next);
            end
            default: begin
                state_next = T_LOAD;
            end
        endcase
    end

    smtl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PER_LIST)) u_ram_a (
        .aclk  (aclk),
        .we    (req_a.we),
        .waddr (req_a.waddr),
        .wdata (req_a.wdata),
        .raddr (req_a.raddr),
        .rdata (rdata_a)
    );

    smtl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PER_LIST)) u_ram_b (
        .aclk  (aclk),
        .we    (req_b.we),
        .waddr (req_b.waddr),
        .wdata (req_b.wdata),
        .raddr (req_b.raddr),
        .rdata (rdata_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_LOAD;
            ca_reg     <= '0;
            cb_reg     <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ca_reg     <= ca_next;
            cb_reg     <= cb_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    // The lists are never written while the merge reads them.
    a_no_write_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_MERGE) |-> (!req_a.we && !req_b.we))
        else $error("list memory written during merge");

    // The merge never runs past the words it holds.
    a_merge_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_MERGE) |-> (done_cnt < total))
        else $error("merge index beyond list contents");

    // Emitting the last word of a run clears the set.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && is_last) |=> (ca_reg == '0 && cb_reg == '0 && !ovf_reg))
        else $error("counts not cleared after last word");

    // Counts never pass the list capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ca_reg <= CNT_W'(MAX_PER_LIST)) && (cb_reg <= CNT_W'(MAX_PER_LIST)))
        else $error("list count beyond capacity");

endmodule

[bench/sort_and_merge_two_lists_tb.sv]
// Self-checking testbench for sort_and_merge_two_lists: loads sets of words into both lists
// and checks every merged word against its own predictor. Depends on smtl_pkg and the block.
`timescale 1ns / 100ps

module sort_and_merge_two_lists_tb;
    import smtl_pkg::*;

    localparam int IDLE_LIMIT    = 10000;
    localparam int ITEMS_PER_MIX = 85;

    typedef word_t word_list_t [MAX_PER_LIST];

    typedef struct packed {
        word_t value;
        logic  last;
        logic  dropped;
    } merged_word_t;

    logic  aclk     = 1'b0;
    logic  aresetn  = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    word_t s_tdata  = '0;    // element_value
    logic  s_tlast  = 1'b0;  // end_of_load
    logic  s_tuser  = 1'b0;  // command: 0 first list, 1 second list
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    word_t m_tdata;          // merged_value
    logic  m_tlast;          // last_of_run
    logic  m_tuser;          // dropped_flag

    sort_and_merge_two_lists dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: a copy of both lists, their fill levels and the list-full flag.
    word_list_t   first_words;
    word_list_t   second_words;
    int           first_fill   = 0;
    int           second_fill  = 0;
    bit           words_dropped = 1'b0;
    merged_word_t expected_merge [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    int error_count     = 0;
    int words_sent      = 0;
    int sets_sent       = 0;
    int merged_checked  = 0;
    int merged_dropped  = 0;
    int idle_cycles     = 0;

    function automatic word_list_t sorted_words(input word_list_t words, input int count);
        word_list_t w;
        word_t      v;
        int         j;
        w = words;
        for (int i = 1; i < count; i++) begin
            v = w[i];
            j = i;
            while (j > 0 && w[j-1] > v) begin
                w[j] = w[j-1];
                j--;
            end
            w[j] = v;
        end
        return w;
    endfunction

    // Stores one accepted word; on end of load, queues the ascending merge of both lists.
    function automatic void predict_merge(input logic sel, input word_t value, input logic eol);
        word_list_t   a;
        word_list_t   b;
        merged_word_t r;
        int           ia;
        int           ib;
        int           total;
        if (sel == 1'b0) begin
            if (first_fill < MAX_PER_LIST) begin
                first_words[first_fill] = value;
                first_fill++;
            end else begin
                words_dropped = 1'b1;
            end
        end else begin
            if (second_fill < MAX_PER_LIST) begin
                second_words[second_fill] = value;
                second_fill++;
            end else begin
                words_dropped = 1'b1;
            end
        end
        if (!eol)
            return;
        a = sorted_words(first_words, first_fill);
        b = sorted_words(second_words, second_fill);
        total = first_fill + second_fill;
        ia = 0;
        ib = 0;
        for (int k = 0; k < total; k++) begin
            // On equal values the word from the first list goes out first.
            if (ia < first_fill && (ib >= second_fill || a[ia] <= b[ib])) begin
                r.value = a[ia];
                ia++;
            end else begin
                r.value = b[ib];
                ib++;
            end
            r.last    = (k + 1 == total);
            r.dropped = words_dropped;
            expected_merge.push_back(r);
        end
        first_fill    = 0;
        second_fill   = 0;
        words_dropped = 1'b0;
    endfunction

    // Offers one word, idling first at the current rate, and returns once it is accepted.
    task automatic send_word(input logic sel, input word_t value, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= eol;
        s_tuser  <= sel;
        do @(posedge aclk); while (!s_tready);
        predict_merge(sel, value, eol);
        words_sent++;
        if (eol)
            sets_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_merge.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic word_t pick_value;
        case ($urandom_range(7))
            0: case ($urandom_range(3))
                   0: return word_t'(32'h8000_0000);
                   1: return word_t'(32'h7fff_ffff);
                   2: return word_t'(0);
                   default: return word_t'(-1);
               endcase
            1: return word_t'($urandom_range(8)) - word_t'(4);
            default: return word_t'($urandom());
        endcase
    endfunction

    // One load of random length; the list choice is skewed per set so lists can fill up.
    task automatic send_random_set;
        int size;
        int sel_pct;
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            size = $urandom_range(12, 1);
        else if (pick < 95)
            size = $urandom_range(40, 13);
        else
            size = $urandom_range(70, 60);
        sel_pct = 25 * $urandom_range(4);
        for (int i = 0; i < size; i++)
            send_word($urandom_range(99) < sel_pct, pick_value(), i == size - 1);
    endtask

    task automatic run_random_sets(input int items);
        int start;
        start = words_sent;
        while (words_sent - start < items)
            send_random_set();
        drain();
    endtask

    task automatic test_directed;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // A set of one word, in each list, at both ends of the range.
        send_word(1'b0, word_t'(32'h8000_0000), 1'b1);
        send_word(1'b1, word_t'(32'h7fff_ffff), 1'b1);
        // Mixed signs, ties across the lists and both extremes in one set.
        send_word(1'b0, word_t'(5), 1'b0);
        send_word(1'b1, word_t'(5), 1'b0);
        send_word(1'b0, word_t'(-1), 1'b0);
        send_word(1'b1, word_t'(32'h7fff_ffff), 1'b0);
        send_word(1'b1, word_t'(0), 1'b0);
        send_word(1'b0, word_t'(32'h7fff_ffff), 1'b0);
        send_word(1'b1, word_t'(32'h8000_0000), 1'b0);
        send_word(1'b0, word_t'(32'h8000_0000), 1'b1);
        // Descending input into the second list only.
        for (int i = 0; i < 6; i++)
            send_word(1'b1, word_t'(100 - 37 * i), i == 5);
        drain();
    endtask

    task automatic test_list_full;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Fill the first list, overrun it, and let the end-of-load word be dropped too.
        for (int i = 0; i < MAX_PER_LIST + 1; i++)
            send_word(1'b0, pick_value(), 1'b0);
        send_word(1'b0, pick_value(), 1'b1);
        // Both lists full: the longest possible run.
        for (int i = 0; i < 2 * MAX_PER_LIST; i++)
            send_word(i[0], pick_value(), i == 2 * MAX_PER_LIST - 1);
        drain();
    endtask

    task automatic test_random_no_idle;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_sets(ITEMS_PER_MIX);
    endtask

    task automatic test_random_sender_idle;
        send_idle_pct  = 66;
        recv_stall_pct = 0;
        run_random_sets(ITEMS_PER_MIX);
    endtask

    task automatic test_random_receiver_stall;
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        run_random_sets(ITEMS_PER_MIX);
    endtask

    task automatic test_random_both_idle;
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_random_sets(ITEMS_PER_MIX);
    endtask

    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // The output is held off while several sets are offered back to back.
        hold_left = 1500;
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < 16; i++)
                send_word($urandom_range(1), pick_value(), i == 15);
        drain();
    endtask

    // Output side: random stalls, or a long hold-off counted down here.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic void report_field(input string field, input word_t want, input word_t got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        merged_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            merged_checked++;
            if (m_tuser)
                merged_dropped++;
            if (expected_merge.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word, expected none, got %0d", $time, m_tdata);
            end else begin
                want = expected_merge.pop_front();
                if (m_tdata !== want.value)
                    report_field("merged_value", want.value, m_tdata);
                if (m_tlast !== want.last)
                    report_field("last_of_run", word_t'(want.last), word_t'(m_tlast));
                if (m_tuser !== want.dropped)
                    report_field("dropped_flag", word_t'(want.dropped), word_t'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("sort_and_merge_two_lists_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_list_full();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();

        if (expected_merge.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected words never arrived", $time, expected_merge.size());
        end
        $display("Loaded %0d words in %0d sets under four idling mixes and a long hold-off.",
                 words_sent, sets_sent);
        $display("Checked %0d merged words, %0d of them flagged for a full list.",
                 merged_checked, merged_dropped);
        if (error_count == 0)
            $display("sort_and_merge_two_lists_tb: clean");
        else
            $display("sort_and_merge_two_lists_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
src/smtl_pkg.sv
src/smtl_ram.sv
src/smtl_sorter.sv
src/sort_and_merge_two_lists.sv
bench/sort_and_merge_two_lists_tb.sv
